>>> rtl/rcbp_pkg.sv
// Shared types, constants and the cosine table generator for the breathing PWM envelope.
// Used by the channel interfaces, the serial divider, the serial multiplier and the top level.
// No dependencies.
`default_nettype none

package rcbp_pkg;

  // Field and datapath widths.
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned PHASE_W     = 16;
  localparam int unsigned DATA_W      = 16;
  localparam int unsigned BITS_W      = 5;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned X_W         = DATA_W + 1;
  localparam int unsigned DIV_STEPS   = TIME_W + PHASE_W;
  localparam int unsigned MUL_DIGIT_W = 2;
  localparam int unsigned MUL_DIGITS  = DATA_W / MUL_DIGIT_W;

  // Default size of the quarter-wave cosine table (log2 of the segment count).
  localparam int unsigned COS_TABLE_BITS_DEF = 8;

  // Register reset values.
  localparam logic [DATA_W-1:0] PERIOD_RST    = 16'd4000;
  localparam logic [DATA_W-1:0] STRENGTH_RST  = 16'hFFFF;
  localparam logic [DATA_W-1:0] DEADZONE_RST  = 16'h0000;
  localparam logic [BITS_W-1:0] DUTY_BITS_RST = 5'd8;

  // One in Q1.15 (a half on the 17-bit x scale) and pi/2 in Q30.
  localparam logic [X_W-1:0] HALF_Q15    = 17'd32768;
  localparam logic [63:0]    HALF_PI_Q30 = 64'd1686629713;

  // Request kinds.
  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_ENABLE = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD,
    CFG_STRENGTH,
    CFG_DEADZONE,
    CFG_DUTY_BITS
  } rcbp_cfg_e;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ROM,
    ST_SCALE_GO,
    ST_SCALE,
    ST_DUTY_GO,
    ST_DUTY,
    ST_FINISH
  } rcbp_state_e;

  // Status of a serial arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } rcbp_unit_sts_t;

  // Cosine table entry k in Q1.15 for a table of 2^bits segments over a quarter wave.
  // The series is evaluated in Q30 to the thirteenth Taylor term, then clamped and rounded.
  function automatic logic [DATA_W-1:0] cos_q15(int unsigned k, int unsigned bits);
    logic [63:0] theta;
    logic [63:0] th2;
    logic [63:0] term;
    logic [63:0] rnd;
    longint      acc;
    theta = (HALF_PI_Q30 * 64'(k) + (64'd1 << (bits - 1))) >> bits;
    th2   = (theta * theta) >> 30;
    term  = 64'd1 << 30;
    acc   = longint'(1) << 30;
    for (int n = 1; n <= 12; n++) begin
      term = (term * th2) >> 30;
      term = term / 64'((2 * n - 1) * (2 * n));
      if ((n & 1) != 0) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > (longint'(1) << 30)) begin
      acc = longint'(1) << 30;
    end
    rnd = 64'(acc) + (64'd1 << 14);
    return DATA_W'(rnd >> 15);
  endfunction

endpackage

`default_nettype wire

>>> rtl/rcbp_if.sv
// Valid/ready channel interfaces for requests into and results out of the breathing PWM block.
// Depends on rcbp_pkg for field widths.
`default_nettype none

// Request channel: update tick or enable change with a millisecond timestamp.
interface rcbp_in_if import rcbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic              enable;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, output kind, output enable, output now_ms, input ready);
  modport sink   (input valid, input kind, input enable, input now_ms, output ready);
endinterface

// Result channel: duty value and the enable flag after the request.
interface rcbp_out_if import rcbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] duty;
  logic              enabled;

  modport source (output valid, output duty, output enabled, input ready);
  modport sink   (input valid, input duty, input enabled, output ready);
endinterface

`default_nettype wire

>>> rtl/raised_cosine_breathing_pwm.sv
// Enable events and updates while disabled go from idle to the finish state, which loads the
// output register once it is free. Updates while enabled pass through the 48-step bit-serial
// divider, the table read and two 8-step multiplies; no new request is taken until idle again.
// A request is taken while an earlier result still waits in the output register.
// Reset restores the register defaults and clears the enable flag and breath start; the
// cosine table is constant and needs no clearing.
`default_nettype none

module raised_cosine_breathing_pwm import rcbp_pkg::*; #(
  parameter int unsigned COS_TABLE_BITS = COS_TABLE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  rcbp_in_if.sink              in_i,
  rcbp_out_if.source           out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned CosN     = 1 << COS_TABLE_BITS;
  localparam int unsigned CosDepth = CosN + 1;
  localparam int unsigned AddrW    = COS_TABLE_BITS + 1;

  // Largest duty for a resolution, with resolutions above the field width taken as full width.
  function automatic logic [DATA_W-1:0] max_duty(logic [BITS_W-1:0] bits);
    logic [BITS_W-1:0] lim;
    lim = (bits > BITS_W'(DATA_W)) ? BITS_W'(DATA_W) : bits;
    return ~({DATA_W{1'b1}} << lim);
  endfunction

  // Configuration registers.
  logic [DATA_W-1:0] period_q;
  logic [DATA_W-1:0] strength_q;
  logic [DATA_W-1:0] deadzone_q;
  logic [BITS_W-1:0] duty_bits_q;

  // Sequencer, breath state and datapath registers.
  rcbp_state_e       state_q, state_d;
  logic              active_q;
  logic [TIME_W-1:0] breath_start_q;
  logic [TIME_W-1:0] now_q;
  logic [DATA_W-1:0] rom_q;
  logic [DATA_W-1:0] y_q;
  logic [DATA_W-1:0] duty_q;
  logic              out_valid_q;
  logic [DATA_W-1:0] out_duty_q;
  logic              out_enabled_q;

  // Handshake and unit control.
  logic              in_ready;
  logic              accept;
  logic              div_start;
  logic              mul_start;
  logic              out_load;
  logic [X_W-1:0]    mul_a;
  logic [DATA_W-1:0] mul_b;

  // Unit interfaces.
  rcbp_unit_sts_t       div_sts;
  rcbp_unit_sts_t       mul_sts;
  logic [DATA_W-1:0]    div_mod;
  logic [PHASE_W-1:0]   div_quo;
  logic [X_W-1:0]       mul_hi;
  logic [DATA_W-1:0]    per;
  logic [DIV_STEPS-1:0] dividend;

  // Table lookup and scaling.
  logic [DATA_W-1:0]         cos_rom [CosDepth];
  logic [COS_TABLE_BITS-1:0] idx;
  logic                      mirror;
  logic                      negate;
  logic [AddrW-1:0]          rom_addr;
  logic [X_W-1:0]            x;
  logic [DATA_W-1:0]         y_d;
  logic [DATA_W-1:0]         maxd;
  logic [DATA_W-1:0]         duty_sat;

  // Quarter-wave cosine table, fixed at elaboration.
  for (genvar k = 0; k < CosDepth; k++) begin : g_cos_rom
    assign cos_rom[k] = cos_q15(k, COS_TABLE_BITS);
  end

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= PERIOD_RST;
      strength_q  <= STRENGTH_RST;
      deadzone_q  <= DEADZONE_RST;
      duty_bits_q <= DUTY_BITS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PERIOD:    period_q    <= cfg_data_i;
        CFG_STRENGTH:  strength_q  <= cfg_data_i;
        CFG_DEADZONE:  deadzone_q  <= cfg_data_i;
        CFG_DUTY_BITS: duty_bits_q <= cfg_data_i[BITS_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = (in_i.kind == KIND_UPDATE && active_q) ? ST_DIV : ST_FINISH;
        end
      end
      ST_DIV: begin
        if (div_sts.done) begin
          state_d = ST_ROM;
        end
      end
      ST_ROM:      state_d = ST_SCALE_GO;
      ST_SCALE_GO: state_d = ST_SCALE;
      ST_SCALE: begin
        if (mul_sts.done) begin
          state_d = ST_DUTY_GO;
        end
      end
      ST_DUTY_GO:  state_d = ST_DUTY;
      ST_DUTY: begin
        if (mul_sts.done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshakes, unit starts and multiplier operands.
  always_comb begin
    in_ready  = (state_q == ST_IDLE);
    accept    = in_ready && in_i.valid;
    div_start = accept && (in_i.kind == KIND_UPDATE) && active_q;
    mul_start = (state_q == ST_SCALE_GO) || (state_q == ST_DUTY_GO);
    out_load  = (state_q == ST_FINISH) && (!out_valid_q || out_o.ready);
    if (state_q == ST_SCALE_GO) begin
      mul_a = x;
      mul_b = strength_q;
    end else begin
      mul_a = {1'b0, y_q};
      mul_b = maxd;
    end
  end

  // Elapsed time with sixteen fraction bits appended, over a period that is never zero.
  always_comb begin
    per      = (period_q == '0) ? DATA_W'(1) : period_q;
    dividend = {in_i.now_ms - breath_start_q, {PHASE_W{1'b0}}};
  end

  // Quadrant handling: odd quadrants read the table mirrored, the middle two add the cosine.
  always_comb begin
    idx      = div_quo[PHASE_W-3 -: COS_TABLE_BITS];
    mirror   = div_quo[PHASE_W-2];
    negate   = div_quo[PHASE_W-1] ^ div_quo[PHASE_W-2];
    rom_addr = mirror ? (AddrW'(CosN) - {1'b0, idx}) : {1'b0, idx};
    x        = negate ? (HALF_Q15 + {1'b0, rom_q}) : (HALF_Q15 - {1'b0, rom_q});
  end

  // Deadzone cut on the scaled level and saturation of the duty.
  always_comb begin
    y_d      = (mul_hi[DATA_W-1:0] < deadzone_q) ? '0 : mul_hi[DATA_W-1:0];
    maxd     = max_duty(duty_bits_q);
    duty_sat = (mul_hi[DATA_W-1:0] > maxd) ? maxd : mul_hi[DATA_W-1:0];
  end

  // Control state: sequencer, enable flag, breath start and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      active_q       <= 1'b0;
      breath_start_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept && in_i.kind == KIND_ENABLE) begin
        active_q <= in_i.enable;
        if (in_i.enable) begin
          breath_start_q <= in_i.now_ms;
        end
      end else if (state_q == ST_DIV && div_sts.done) begin
        // Move the breath start forward by whole periods.
        breath_start_q <= now_q - TIME_W'(div_mod);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q  <= in_i.now_ms;
      duty_q <= '0;
    end
    if (state_q == ST_ROM) begin
      rom_q <= cos_rom[rom_addr];
    end
    if (state_q == ST_SCALE && mul_sts.done) begin
      y_q <= y_d;
    end
    if (state_q == ST_DUTY && mul_sts.done) begin
      duty_q <= duty_sat;
    end
    if (out_load) begin
      out_duty_q    <= duty_q;
      out_enabled_q <= active_q;
    end
  end

  // Elapsed-time fold and phase.
  rcbp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (per),
    .sts_o      (div_sts),
    .mod_o      (div_mod),
    .quo_o      (div_quo)
  );

  // Shared multiplier for strength and duty scaling.
  rcbp_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .sts_o   (mul_sts),
    .hi_o    (mul_hi)
  );

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.duty    = out_duty_q;
  assign out_o.enabled = out_enabled_q;

  // Checks.
  a_ready_units_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> (!div_sts.busy && !mul_sts.busy))
    else $error("request taken while an arithmetic unit is busy");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide phase");

  a_mul_done_in_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_sts.done |-> (state_q == ST_SCALE || state_q == ST_DUTY))
    else $error("multiplier finished outside a scaling phase");

  a_off_means_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.enabled) |-> (out_o.duty == '0))
    else $error("nonzero duty while disabled");

  a_duty_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.duty <= max_duty(duty_bits_q)))
    else $error("duty above the maximum for the resolution");

endmodule

`default_nettype wire

>>> rtl/rcbp_div.sv
// Bit-serial restoring divider: folds the elapsed time by the period and forms the phase.
// One quotient bit per cycle; depends on rcbp_pkg.
`default_nettype none

module rcbp_div import rcbp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DIV_STEPS-1:0] dividend_i,
  input  logic [DATA_W-1:0]    divisor_i,
  output rcbp_unit_sts_t       sts_o,
  output logic [DATA_W-1:0]    mod_o,
  output logic [PHASE_W-1:0]   quo_o
);

  localparam int unsigned CntW = $clog2(DIV_STEPS);
  localparam logic [CntW-1:0] ModStep  = CntW'(TIME_W - 1);
  localparam logic [CntW-1:0] LastStep = CntW'(DIV_STEPS - 1);

  logic [DIV_STEPS-1:0] num_q;
  logic [DATA_W-1:0]    rem_q, rem_d;
  logic [DATA_W-1:0]    dsr_q;
  logic [PHASE_W-1:0]   quo_q;
  logic [DATA_W-1:0]    mod_q;
  logic [CntW-1:0]      cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [DATA_W:0]      shifted;
  logic [DATA_W:0]      diff;
  logic                 fits;

  // One restoring step: bring in the next dividend bit and subtract the divisor if it fits.
  always_comb begin
    shifted = {rem_q, num_q[DIV_STEPS-1]};
    fits    = shifted >= {1'b0, dsr_q};
    diff    = shifted - {1'b0, dsr_q};
    rem_d   = fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
  end

  // Step counter and handshake with the sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Dividend shift register, partial remainder and quotient bits.
  // After the time bits have gone through, the remainder is the folded time.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[DIV_STEPS-2:0], 1'b0};
      rem_q <= rem_d;
      quo_q <= {quo_q[PHASE_W-2:0], fits};
      if (cnt_q == ModStep) begin
        mod_q <= rem_d;
      end
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign mod_o      = mod_q;
  assign quo_o      = quo_q;

endmodule

`default_nettype wire

>>> rtl/rcbp_mul.sv
// Digit-serial multiplier: two multiplier bits per cycle, keeps only the upper product half.
// Depends on rcbp_pkg.
`default_nettype none

module rcbp_mul import rcbp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [X_W-1:0]    a_i,
  input  logic [DATA_W-1:0] b_i,
  output rcbp_unit_sts_t    sts_o,
  output logic [X_W-1:0]    hi_o
);

  localparam int unsigned CntW = $clog2(MUL_DIGITS);
  localparam int unsigned SumW = X_W + MUL_DIGIT_W;
  localparam logic [CntW-1:0] LastStep = CntW'(MUL_DIGITS - 1);

  logic [X_W-1:0]    a_q;
  logic [DATA_W-1:0] b_q;
  logic [X_W-1:0]    hi_q;
  logic [CntW-1:0]   cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [SumW-1:0]   addend;
  logic [SumW-1:0]   sum;

  // Partial product of the current radix-4 digit, added to the running upper half.
  always_comb begin
    case (b_q[MUL_DIGIT_W-1:0])
      2'd0:    addend = '0;
      2'd1:    addend = {2'b00, a_q};
      2'd2:    addend = {1'b0, a_q, 1'b0};
      2'd3:    addend = {2'b00, a_q} + {1'b0, a_q, 1'b0};
      default: addend = '0;
    endcase
    sum = {2'b00, hi_q} + addend;
  end

  // Digit counter and handshake with the sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift-add datapath; the low product bits fall off the right end.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      b_q  <= b_i;
      hi_q <= '0;
    end else if (busy_q) begin
      b_q  <= {{MUL_DIGIT_W{1'b0}}, b_q[DATA_W-1:MUL_DIGIT_W]};
      hi_q <= sum[SumW-1:MUL_DIGIT_W];
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign hi_o       = hi_q;

endmodule

`default_nettype wire

>>> tb/sv/raised_cosine_breathing_pwm_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the raised-cosine breathing PWM envelope block.
// Drives requests through rcbp_in_if, checks results on rcbp_out_if against an in-bench
// envelope predictor; depends on rcbp_pkg, rcbp_if.sv and the top level RTL.

module raised_cosine_breathing_pwm_tb import rcbp_pkg::*; ();

  localparam int unsigned COS_BITS   = COS_TABLE_BITS_DEF;
  localparam int unsigned COS_N      = 1 << COS_BITS;
  localparam int unsigned IDLE_PCT   = 38;
  localparam int unsigned HOLD_LEN   = 300;
  localparam int unsigned TAIL_WAIT  = 100;
  localparam longint      CYCLE_CAP  = 1000000;
  localparam int unsigned BURST_LEN  = 85;
  localparam int unsigned PRINT_CAP  = 50;

  typedef struct packed {
    logic              kind;
    logic              enable;
    logic [TIME_W-1:0] now_ms;
  } breath_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] duty;
    logic              enabled;
  } duty_res_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DATA_W-1:0]    cfg_data_i;

  rcbp_in_if  in_if ();
  rcbp_out_if out_if ();

  raised_cosine_breathing_pwm i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Stimulus and expectation stores.
  breath_req_t request_q [$];
  duty_res_t   duty_expect_q [$];
  breath_req_t req_on_bus;
  duty_res_t   duty_seen;
  duty_res_t   duty_want;

  // Predictor copy of the registers and the breathing state.
  logic [DATA_W-1:0] period_m;
  logic [DATA_W-1:0] strength_m;
  logic [DATA_W-1:0] deadzone_m;
  logic [BITS_W-1:0] duty_bits_m;
  logic              active_m;
  logic [TIME_W-1:0] breath_start_m;
  logic [DATA_W-1:0] cos_tab [0:COS_N];

  int unsigned err_cnt;
  int unsigned req_count;
  int unsigned hold_left;
  longint      cycle_cnt;
  logic        calm;

  // Clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Quarter-wave cosine entry in Q1.15, Taylor series evaluated in Q30.
  function automatic logic [DATA_W-1:0] cos_entry(int unsigned k);
    logic [63:0] ang;
    logic [63:0] ang2;
    logic [63:0] tk;
    longint      sum;
    int          n;
    ang  = (HALF_PI_Q30 * 64'(k) + (64'd1 << (COS_BITS - 1))) >> COS_BITS;
    ang2 = (ang * ang) >> 30;
    tk   = 64'd1 << 30;
    sum  = longint'(1) << 30;
    for (n = 1; n <= 12; n++) begin
      tk = (tk * ang2) >> 30;
      tk = tk / 64'((2 * n - 1) * (2 * n));
      if ((n % 2) == 1) begin
        sum = sum - longint'(tk);
      end else begin
        sum = sum + longint'(tk);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > (longint'(1) << 30)) begin
      sum = longint'(1) << 30;
    end
    return DATA_W'((64'(sum) + 64'd16384) >> 15);
  endfunction

  // Envelope level for elapsed time t inside one period, scaled to the duty range.
  function automatic logic [DATA_W-1:0] envelope_duty(logic [31:0] t, logic [31:0] per);
    logic [47:0]  ph48;
    logic [15:0]  phase;
    int unsigned  idx;
    int           c;
    logic [31:0]  x;
    logic [31:0]  y;
    logic [31:0]  maxd;
    logic [31:0]  d;
    int unsigned  bits;
    ph48  = {t, 16'h0000} / {16'h0000, per};
    phase = ph48[15:0];
    idx   = int'(phase[13:0]) >> (14 - COS_BITS);
    case (phase[15:14])
      2'd0:    c = int'(cos_tab[idx]);
      2'd1:    c = -int'(cos_tab[COS_N - idx]);
      2'd2:    c = -int'(cos_tab[idx]);
      default: c = int'(cos_tab[COS_N - idx]);
    endcase
    x = 32'(32768 - c);
    y = 32'((64'(x) * 64'(strength_m)) >> 16);
    if (y < 32'(deadzone_m)) begin
      y = 0;
    end
    bits = (duty_bits_m > 5'd16) ? 16 : int'(duty_bits_m);
    maxd = (32'd1 << bits) - 32'd1;
    d    = 32'((64'(y) * 64'(maxd)) >> 16);
    if (d > maxd) begin
      d = maxd;
    end
    return d[DATA_W-1:0];
  endfunction

  // Advances the breathing state for one accepted request and returns its result.
  function automatic duty_res_t predict_duty(breath_req_t req);
    duty_res_t   res;
    logic [31:0] per;
    logic [31:0] t;
    res.duty = '0;
    if (req.kind == KIND_ENABLE) begin
      active_m = req.enable;
      if (req.enable) begin
        breath_start_m = req.now_ms;
      end
    end else if (active_m) begin
      per = (period_m == '0) ? 32'd1 : 32'(period_m);
      t   = req.now_ms - breath_start_m;
      if (t >= per) begin
        t              = t % per;
        breath_start_m = req.now_ms - t;
      end
      res.duty = envelope_duty(t, per);
    end
    res.enabled = active_m;
    return res;
  endfunction

  function automatic logic idle_roll();
    return !calm && ($urandom_range(99) < IDLE_PCT);
  endfunction

  task automatic report_mismatch(string msg);
    if (err_cnt < PRINT_CAP) begin
      $display("MISMATCH at cycle %0d: %s", cycle_cnt, msg);
    end
    err_cnt++;
  endtask

  // Request driver: predicts each request as it is accepted, then offers the next one.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        duty_expect_q.push_back(predict_duty(req_on_bus));
        req_count <= req_count + 1;
      end
      if (!in_if.valid || in_if.ready) begin
        if (request_q.size() != 0 && !idle_roll()) begin
          req_on_bus    = request_q.pop_front();
          in_if.valid  <= 1'b1;
          in_if.kind   <= req_on_bus.kind;
          in_if.enable <= req_on_bus.enable;
          in_if.now_ms <= req_on_bus.now_ms;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started every so many accepted requests.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (in_if.valid && in_if.ready && (req_count % 211) == 60) begin
      hold_left <= HOLD_LEN;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        duty_seen.duty    = out_if.duty;
        duty_seen.enabled = out_if.enabled;
        if (duty_expect_q.size() == 0) begin
          report_mismatch($sformatf("result with no request pending, duty %0d",
                                    duty_seen.duty));
        end else begin
          duty_want = duty_expect_q.pop_front();
          if (duty_seen.duty !== duty_want.duty) begin
            report_mismatch($sformatf("duty got %0d want %0d", duty_seen.duty,
                                      duty_want.duty));
          end
          if (duty_seen.enabled !== duty_want.enabled) begin
            report_mismatch($sformatf("enabled got %0b want %0b", duty_seen.enabled,
                                      duty_want.enabled));
          end
        end
      end
      out_if.ready <= (hold_left == 0) && !idle_roll();
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("raised_cosine_breathing_pwm verification failed");
      $finish;
    end
  end

  task automatic push_req(logic kind, logic enable, logic [TIME_W-1:0] now_ms);
    breath_req_t req;
    req.kind   = kind;
    req.enable = enable;
    req.now_ms = now_ms;
    request_q.push_back(req);
  endtask

  // Waits until every request has gone in and every result has come back.
  task automatic drain();
    @(negedge clk_i);
    while (request_q.size() != 0 || in_if.valid || duty_expect_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Writes all four registers back to back, only while the block is idle.
  task automatic program_regs(logic [15:0] per, logic [15:0] str, logic [15:0] dz,
                              logic [4:0] bits);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_PERIOD;
    cfg_data_i <= per;
    period_m    = per;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_STRENGTH;
    cfg_data_i <= str;
    strength_m  = str;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_DEADZONE;
    cfg_data_i <= dz;
    deadzone_m  = dz;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_DUTY_BITS;
    cfg_data_i <= {11'($urandom), bits};
    duty_bits_m = bits;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Mostly well-formed breaths: an enable, then updates stepping forward in time.
  // The rest are disables, restarts and requests at arbitrary timestamps.
  task automatic random_burst(int unsigned n);
    logic [31:0] clk_ms;
    logic [31:0] per;
    int unsigned r;
    per    = (period_m == '0) ? 32'd1 : 32'(period_m);
    clk_ms = $urandom;
    push_req(KIND_ENABLE, 1'b1, clk_ms);
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 7) begin
        push_req(KIND_ENABLE, 1'b1, clk_ms);
      end else if (r < 9) begin
        push_req(KIND_ENABLE, 1'b0, $urandom);
      end else if (r < 14) begin
        push_req(1'($urandom), 1'($urandom), $urandom);
      end else begin
        clk_ms = clk_ms + $urandom_range(0, 2 * per);
        push_req(KIND_UPDATE, 1'($urandom), clk_ms);
      end
    end
    drain();
  endtask

  initial begin
    int unsigned k;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_PERIOD;
    cfg_data_i     = '0;
    in_if.valid    = 1'b0;
    in_if.kind     = KIND_UPDATE;
    in_if.enable   = 1'b0;
    in_if.now_ms   = '0;
    out_if.ready   = 1'b0;
    err_cnt        = 0;
    req_count      = 0;
    cycle_cnt      = 0;
    calm           = 1'b0;
    period_m       = PERIOD_RST;
    strength_m     = STRENGTH_RST;
    deadzone_m     = DEADZONE_RST;
    duty_bits_m    = DUTY_BITS_RST;
    active_m       = 1'b0;
    breath_start_m = '0;
    for (k = 0; k <= COS_N; k++) begin
      cos_tab[k] = cos_entry(k);
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests at the reset settings: updates while disabled, wrap of the
    // timestamp, exact period boundary, time running backwards and restarts.
    push_req(KIND_UPDATE, 1'b0, 32'h0000_0000);
    push_req(KIND_UPDATE, 1'b1, 32'hFFFF_FFFF);
    push_req(KIND_ENABLE, 1'b0, 32'h0000_1234);
    push_req(KIND_ENABLE, 1'b1, 32'hFFFF_FF00);
    push_req(KIND_UPDATE, 1'b0, 32'hFFFF_FF00);
    push_req(KIND_UPDATE, 1'b0, 32'hFFFF_FF00 + 32'd1000);
    push_req(KIND_UPDATE, 1'b0, 32'hFFFF_FF00 + 32'd2000);
    push_req(KIND_UPDATE, 1'b0, 32'hFFFF_FF00 + 32'd3000);
    push_req(KIND_UPDATE, 1'b0, 32'hFFFF_FF00 + 32'd3999);
    push_req(KIND_UPDATE, 1'b0, 32'hFFFF_FF00 + 32'd4000);
    push_req(KIND_UPDATE, 1'b0, 32'hFFFF_FF00 + 32'd12345);
    push_req(KIND_UPDATE, 1'b0, 32'h0000_0000);
    push_req(KIND_ENABLE, 1'b1, 32'h1234_5678);
    push_req(KIND_UPDATE, 1'b0, 32'h1234_5678 + 32'd500);
    push_req(KIND_UPDATE, 1'b1, 32'h1234_5678 + 32'd1500);
    push_req(KIND_UPDATE, 1'b0, 32'h1234_5677);
    push_req(KIND_ENABLE, 1'b0, 32'hA5A5_5A5A);
    push_req(KIND_UPDATE, 1'b0, 32'h1234_5678 + 32'd2000);
    push_req(KIND_ENABLE, 1'b1, 32'h0000_0000);
    push_req(KIND_UPDATE, 1'b0, 32'd2000);
    push_req(KIND_UPDATE, 1'b1, 32'hFFFF_FFFF);
    drain();

    // Register extremes, then random settings.
    program_regs(16'd1, 16'hFFFF, 16'h0000, 5'd16);
    random_burst(BURST_LEN);
    program_regs(16'd0, 16'hFFFF, 16'h0000, 5'd8);
    random_burst(BURST_LEN);
    calm = 1'b1;
    program_regs(16'hFFFF, 16'hFFFF, 16'h0000, 5'd16);
    random_burst(BURST_LEN);
    calm = 1'b0;
    program_regs(16'd4000, 16'h0000, 16'h0000, 5'd8);
    random_burst(BURST_LEN);
    program_regs(16'd1000, 16'hFFFF, 16'hFFFF, 5'd8);
    random_burst(BURST_LEN);
    program_regs(16'd360, 16'd8000, 16'd4000, 5'd0);
    random_burst(BURST_LEN);
    program_regs(16'd777, 16'hFFFF, 16'h0000, 5'd1);
    random_burst(BURST_LEN);
    program_regs(16'd200, 16'($urandom), 16'($urandom_range(0, 20000)), 5'd31);
    random_burst(BURST_LEN);
    program_regs(16'($urandom_range(1, 5000)), 16'($urandom), 16'($urandom_range(0, 30000)),
                 5'($urandom_range(1, 16)));
    random_burst(BURST_LEN);
    program_regs(16'($urandom), 16'($urandom), 16'($urandom), 5'($urandom));
    random_burst(BURST_LEN);

    // Let any stray result show up before the verdict.
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (err_cnt == 0 && duty_expect_q.size() == 0) begin
      $display("raised_cosine_breathing_pwm verification clean");
    end else begin
      $display("raised_cosine_breathing_pwm verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/rcbp_pkg.sv
rtl/rcbp_if.sv
rtl/rcbp_div.sv
rtl/rcbp_mul.sv
rtl/raised_cosine_breathing_pwm.sv
tb/sv/raised_cosine_breathing_pwm_tb.sv
